// ===== rtl/rscd_pkg.sv =====
// ----------------------------------------------------------------------------
// rscd_pkg
// Shared types and constants of the ray/segment closest distance unit.
// ----------------------------------------------------------------------------
package rscd_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int RANGE_WIDTH = COORD_WIDTH - 1;
    localparam int DIR_WIDTH   = 16;
    localparam int DIR_FRAC    = 14;

    // 1e-6 in Q.24 and in Q.48
    localparam longint EPS_DOT = 64'sd16;
    localparam longint EPS_DET = 64'sd281474976;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] origin_from_start_x;
        logic signed [COORD_WIDTH-1:0] origin_from_start_y;
        logic signed [COORD_WIDTH-1:0] origin_from_start_z;
        logic signed [COORD_WIDTH-1:0] segment_x;
        logic signed [COORD_WIDTH-1:0] segment_y;
        logic signed [COORD_WIDTH-1:0] segment_z;
        logic signed [DIR_WIDTH-1:0]   dir_x;
        logic signed [DIR_WIDTH-1:0]   dir_y;
        logic signed [DIR_WIDTH-1:0]   dir_z;
        logic [RANGE_WIDTH-1:0]        ray_range;
    } query_t;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] closest_distance;
        logic [RANGE_WIDTH-1:0] ray_t;
    } result_t;

endpackage

// ===== rtl/rscd_frac_div.sv =====
// ----------------------------------------------------------------------------
// rscd_frac_div
// Pipelined clamped fraction num/den in 0..1, one quotient bit per stage,
// with a side word carried alongside.
// ----------------------------------------------------------------------------
module rscd_frac_div #(
    parameter int NUM_W  = 102,
    parameter int FRAC_W = 16,
    parameter int SIDE_W = 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [NUM_W-1:0] den,
    input  logic                    force_zero,
    input  logic [SIDE_W-1:0]       side_in,
    output logic                    out_valid,
    output logic [FRAC_W:0]         quot,
    output logic [SIDE_W-1:0]       side_out
);

    localparam logic [FRAC_W:0] ONE = {1'b1, {FRAC_W{1'b0}}};

    typedef struct packed {
        logic [NUM_W-1:0]  rem;
        logic [NUM_W-1:0]  dvs;
        logic [FRAC_W:0]   q;
        logic              fixed;
        logic [SIDE_W-1:0] side;
    } div_stage_t;

    div_stage_t      st_reg [FRAC_W+1];
    div_stage_t      st0_next;
    logic [FRAC_W:0] vld_reg;

    // clamp cases leave the quotient fixed for the rest of the pipe
    always_comb
    begin
        st0_next.rem   = num;
        st0_next.dvs   = den;
        st0_next.side  = side_in;
        st0_next.fixed = 1'b1;
        st0_next.q     = '0;
        if (force_zero || num[NUM_W-1] || num == '0)
        begin
            st0_next.q = '0;
        end
        else if (num >= den)
        begin
            st0_next.q = ONE;
        end
        else
        begin
            st0_next.fixed = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[FRAC_W-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg[0] <= st0_next;
    end

    for (genvar k = 1; k <= FRAC_W; k++)
    begin : g_step
        div_stage_t       step_next;
        logic [NUM_W:0]   shifted;

        assign shifted = {st_reg[k-1].rem, 1'b0};

        always_comb
        begin
            step_next = st_reg[k-1];
            if (!st_reg[k-1].fixed)
            begin
                if (shifted >= {1'b0, st_reg[k-1].dvs})
                begin
                    step_next.rem = NUM_W'(shifted - {1'b0, st_reg[k-1].dvs});
                    step_next.q   = {st_reg[k-1].q[FRAC_W-1:0], 1'b1};
                end
                else
                begin
                    step_next.rem = shifted[NUM_W-1:0];
                    step_next.q   = {st_reg[k-1].q[FRAC_W-1:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            st_reg[k] <= step_next;
        end
    end

    assign out_valid = vld_reg[FRAC_W];
    assign quot      = st_reg[FRAC_W].q;
    assign side_out  = st_reg[FRAC_W].side;

endmodule

// ===== rtl/ray_segment_closest_distance_unit.sv =====
// ----------------------------------------------------------------------------
// ray_segment_closest_distance_unit
// Closest approach between a ray segment and a line segment in 3-D.
// ----------------------------------------------------------------------------
// Takes one query word in every cycle (busy stays low) and delivers its
// result word on result with done high for exactly one cycle. The three
// chained fraction dividers, one quotient bit per stage, and the bitwise
// square root, one root bit per stage, make up most of the pipeline.
// Results come out in query order; the receiver cannot stall, so the
// output must be taken when done is high.
module ray_segment_closest_distance_unit #(
    parameter int FRACTION_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  rscd_pkg::query_t  query,
    output logic              done,
    output rscd_pkg::result_t result
);
    import rscd_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int FB   = FRACTION_BITS;
    localparam int UW   = CW + 2;
    localparam int DW   = 2 * CW + 3;
    localparam int MW   = 2 * CW + 2;
    localparam int HW   = CW + 1;
    localparam int PPW  = 2 * HW;
    localparam int PW   = 4 * CW + 6;
    localparam int NT   = 2 * CW + FB + 5;
    localparam int PCW  = CW + FB + 3;
    localparam int QW   = CW + 3;
    localparam int RSW  = CW + FB;
    localparam int SQW  = 2 * CW;
    localparam int SW   = 2 * CW + 2;
    localparam int PDW  = DIR_WIDTH + CW;
    localparam int LATENCY = 3 * FB + CW + 18;
    localparam logic [CW-1:0] MAX_DIST = '1;

    typedef struct packed {
        logic [2:0][CW-1:0] w;
        logic [2:0][CW-1:0] v;
        logic [2:0][UW-1:0] u;
        logic [CW-2:0]      ray_len;
        logic [DW-1:0]      a;
        logic [DW-1:0]      b;
        logic [DW-1:0]      c;
        logic [DW-1:0]      d;
        logic [DW-1:0]      e;
        logic [FB:0]        s;
        logic [FB:0]        t;
    } ctx_t;

    localparam int CTXW = $bits(ctx_t);

    function automatic logic [MW-1:0] mag_dw(input logic signed [DW-1:0] x);
        logic [DW-1:0] m;
        m = x[DW-1] ? DW'(-x) : DW'(x);
        return m[MW-1:0];
    endfunction

    assign busy = 1'b0;

    // ---------------- stage 0: capture word
    query_t q0_reg;
    logic   v0_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q0_reg <= query;
        end
    end

    // ---------------- stage 1: ray vector U = d * R
    logic signed [CW-1:0]        in_w [3];
    logic signed [CW-1:0]        in_v [3];
    logic signed [DIR_WIDTH-1:0] in_d [3];
    logic signed [PDW-1:0]       p_d  [3];
    logic [PDW-1:0]              mag_d [3];
    logic [PDW-1:0]              rnd_d [3];
    ctx_t ctx1_reg, ctx1_next;
    logic v1_reg;

    assign in_w[0] = q0_reg.origin_from_start_x;
    assign in_w[1] = q0_reg.origin_from_start_y;
    assign in_w[2] = q0_reg.origin_from_start_z;
    assign in_v[0] = q0_reg.segment_x;
    assign in_v[1] = q0_reg.segment_y;
    assign in_v[2] = q0_reg.segment_z;
    assign in_d[0] = q0_reg.dir_x;
    assign in_d[1] = q0_reg.dir_y;
    assign in_d[2] = q0_reg.dir_z;

    always_comb
    begin
        ctx1_next = '0;
        ctx1_next.ray_len = q0_reg.ray_range;
        for (int i = 0; i < 3; i++)
        begin
            p_d[i]   = PDW'(in_d[i]) * PDW'($signed({1'b0, q0_reg.ray_range}));
            mag_d[i] = p_d[i][PDW-1] ? PDW'(-p_d[i]) : PDW'(p_d[i]);
            rnd_d[i] = (mag_d[i] + (PDW'(1) << (DIR_FRAC - 1))) >> DIR_FRAC;
            ctx1_next.w[i] = in_w[i];
            ctx1_next.v[i] = in_v[i];
            ctx1_next.u[i] = p_d[i][PDW-1] ? UW'(-rnd_d[i]) : UW'(rnd_d[i]);
        end
    end

    // ---------------- stage 2: dot products
    logic signed [UW-1:0] ew [3];
    logic signed [UW-1:0] ev [3];
    logic signed [UW-1:0] eu [3];
    logic signed [DW-1:0] dot_a, dot_b, dot_c, dot_d, dot_e;
    ctx_t ctx2_reg, ctx2_next;
    logic v2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ew[i] = UW'($signed(ctx1_reg.w[i]));
            ev[i] = UW'($signed(ctx1_reg.v[i]));
            eu[i] = $signed(ctx1_reg.u[i]);
        end
        dot_a = '0;
        dot_b = '0;
        dot_c = '0;
        dot_d = '0;
        dot_e = '0;
        for (int i = 0; i < 3; i++)
        begin
            dot_a = dot_a + DW'(eu[i]) * DW'(eu[i]);
            dot_b = dot_b + DW'(eu[i]) * DW'(ev[i]);
            dot_c = dot_c + DW'(ev[i]) * DW'(ev[i]);
            dot_d = dot_d + DW'(eu[i]) * DW'(ew[i]);
            dot_e = dot_e + DW'(ev[i]) * DW'(ew[i]);
        end
        ctx2_next   = ctx1_reg;
        ctx2_next.a = dot_a;
        ctx2_next.b = dot_b;
        ctx2_next.c = dot_c;
        ctx2_next.d = dot_d;
        ctx2_next.e = dot_e;
    end

    // ---------------- stage 3: half-word partial products of AC, BB, BE, CD
    logic signed [DW-1:0] opa [4];
    logic signed [DW-1:0] opb [4];
    logic [MW-1:0]        ma [4];
    logic [MW-1:0]        mb [4];
    logic [PPW-1:0]       pp3_reg  [4][4];
    logic [PPW-1:0]       pp3_next [4][4];
    logic                 neg3_reg  [4];
    logic                 neg3_next [4];
    ctx_t ctx3_reg;
    logic v3_reg;

    always_comb
    begin
        opa[0] = $signed(ctx2_reg.a);
        opb[0] = $signed(ctx2_reg.c);
        opa[1] = $signed(ctx2_reg.b);
        opb[1] = $signed(ctx2_reg.b);
        opa[2] = $signed(ctx2_reg.b);
        opb[2] = $signed(ctx2_reg.e);
        opa[3] = $signed(ctx2_reg.c);
        opb[3] = $signed(ctx2_reg.d);
        for (int k = 0; k < 4; k++)
        begin
            ma[k] = mag_dw(opa[k]);
            mb[k] = mag_dw(opb[k]);
            pp3_next[k][0] = PPW'(ma[k][HW-1:0])  * PPW'(mb[k][HW-1:0]);
            pp3_next[k][1] = PPW'(ma[k][HW-1:0])  * PPW'(mb[k][MW-1:HW]);
            pp3_next[k][2] = PPW'(ma[k][MW-1:HW]) * PPW'(mb[k][HW-1:0]);
            pp3_next[k][3] = PPW'(ma[k][MW-1:HW]) * PPW'(mb[k][MW-1:HW]);
            neg3_next[k]   = opa[k][DW-1] ^ opb[k][DW-1];
        end
    end

    // ---------------- stage 4: combine partials
    logic signed [PW-1:0] psum [4];
    logic signed [PW-1:0] prod4_reg  [4];
    logic signed [PW-1:0] prod4_next [4];
    ctx_t ctx4_reg;
    logic v4_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            psum[k] = PW'(pp3_reg[k][0])
                    + (PW'(pp3_reg[k][1]) << HW)
                    + (PW'(pp3_reg[k][2]) << HW)
                    + (PW'(pp3_reg[k][3]) << (2 * HW));
            prod4_next[k] = neg3_reg[k] ? -psum[k] : psum[k];
        end
    end

    // ---------------- stage 5: determinant and first numerator
    logic signed [PW-1:0] den5_reg, den5_next;
    logic signed [PW-1:0] num5_reg, num5_next;
    logic                 force5_reg, force5_next;
    ctx_t ctx5_reg;
    logic v5_reg;

    assign den5_next   = prod4_reg[0] - prod4_reg[1];
    assign num5_next   = prod4_reg[2] - prod4_reg[3];
    assign force5_next = !(den5_next > PW'(EPS_DET));

    // ---------------- first fraction s
    logic            d1_valid;
    logic [FB:0]     d1_quot;
    logic [CTXW-1:0] d1_side;
    ctx_t            ctx_d1;

    rscd_frac_div #(
        .NUM_W  (PW),
        .FRAC_W (FB),
        .SIDE_W (CTXW)
    ) u_div_s1 (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (v5_reg),
        .num        (num5_reg),
        .den        (den5_reg),
        .force_zero (force5_reg),
        .side_in    (ctx5_reg),
        .out_valid  (d1_valid),
        .quot       (d1_quot),
        .side_out   (d1_side)
    );

    assign ctx_d1 = ctx_t'(d1_side);

    // ---------------- segment fraction t
    ctx_t                 ctxta_reg, ctxta_next;
    logic signed [NT-1:0] bs_reg, bs_next;
    logic                 vta_reg;
    ctx_t                 ctxtb_reg;
    logic signed [NT-1:0] numtb_reg, numtb_next;
    logic signed [NT-1:0] dentb_reg, dentb_next;
    logic                 forcetb_reg, forcetb_next;
    logic                 vtb_reg;

    always_comb
    begin
        ctxta_next   = ctx_d1;
        ctxta_next.s = d1_quot;
        bs_next      = NT'($signed(ctx_d1.b)) * NT'($signed({1'b0, d1_quot}));
    end

    assign numtb_next   = bs_reg + (NT'($signed(ctxta_reg.e)) <<< FB);
    assign dentb_next   = NT'($signed(ctxta_reg.c)) <<< FB;
    assign forcetb_next = !($signed(ctxta_reg.c) > DW'(EPS_DOT));

    logic            d2_valid;
    logic [FB:0]     d2_quot;
    logic [CTXW-1:0] d2_side;
    ctx_t            ctx_d2;

    rscd_frac_div #(
        .NUM_W  (NT),
        .FRAC_W (FB),
        .SIDE_W (CTXW)
    ) u_div_t (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (vtb_reg),
        .num        (numtb_reg),
        .den        (dentb_reg),
        .force_zero (forcetb_reg),
        .side_in    (ctxtb_reg),
        .out_valid  (d2_valid),
        .quot       (d2_quot),
        .side_out   (d2_side)
    );

    assign ctx_d2 = ctx_t'(d2_side);

    // ---------------- refined ray fraction s
    ctx_t                 ctxsa_reg, ctxsa_next;
    logic signed [NT-1:0] bt_reg, bt_next;
    logic                 vsa_reg;
    ctx_t                 ctxsb_reg;
    logic signed [NT-1:0] numsb_reg, numsb_next;
    logic signed [NT-1:0] densb_reg, densb_next;
    logic                 forcesb_reg, forcesb_next;
    logic                 vsb_reg;

    always_comb
    begin
        ctxsa_next   = ctx_d2;
        ctxsa_next.t = d2_quot;
        bt_next      = NT'($signed(ctx_d2.b)) * NT'($signed({1'b0, d2_quot}));
    end

    assign numsb_next   = bt_reg - (NT'($signed(ctxsa_reg.d)) <<< FB);
    assign densb_next   = NT'($signed(ctxsa_reg.a)) <<< FB;
    assign forcesb_next = !($signed(ctxsa_reg.a) > DW'(EPS_DOT));

    logic            d3_valid;
    logic [FB:0]     d3_quot;
    logic [CTXW-1:0] d3_side;
    ctx_t            ctx_d3;

    rscd_frac_div #(
        .NUM_W  (NT),
        .FRAC_W (FB),
        .SIDE_W (CTXW)
    ) u_div_s2 (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (vsb_reg),
        .num        (numsb_reg),
        .den        (densb_reg),
        .force_zero (forcesb_reg),
        .side_in    (ctxsb_reg),
        .out_valid  (d3_valid),
        .quot       (d3_quot),
        .side_out   (d3_side)
    );

    assign ctx_d3 = ctx_t'(d3_side);

    // ---------------- closest-point products
    logic signed [PCW-1:0] us_reg [3];
    logic signed [PCW-1:0] us_next [3];
    logic signed [PCW-1:0] vt_reg [3];
    logic signed [PCW-1:0] vt_next [3];
    logic [RSW-1:0]        rs_reg, rs_next;
    ctx_t                  ctxfa_reg;
    logic                  vfa_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            us_next[i] = PCW'($signed(ctx_d3.u[i])) * PCW'($signed({1'b0, d3_quot}));
            vt_next[i] = PCW'($signed(ctx_d3.v[i])) * PCW'($signed({1'b0, ctx_d3.t}));
        end
        rs_next = RSW'(d3_quot) * RSW'(ctx_d3.ray_len);
    end

    // ---------------- difference, rounding, ray_t
    logic signed [PCW-1:0] pc [3];
    logic [PCW-1:0]        pc_mag [3];
    logic [QW-1:0]         qv_reg [3];
    logic [QW-1:0]         qv_next [3];
    logic                  sat_fb_reg, sat_fb_next;
    logic [RSW-1:0]        rt_full;
    logic [CW-2:0]         rt_fb_reg, rt_fb_next;
    logic                  vfb_reg;

    always_comb
    begin
        sat_fb_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            pc[i] = (PCW'($signed(ctxfa_reg.w[i])) <<< FB) + us_reg[i] - vt_reg[i];
            pc_mag[i] = pc[i][PCW-1] ? PCW'(-pc[i]) : PCW'(pc[i]);
            qv_next[i] = QW'((pc_mag[i] + (PCW'(1) << (FB - 1))) >> FB);
            if (qv_next[i] > QW'(MAX_DIST))
            begin
                sat_fb_next = 1'b1;
            end
        end
        rt_full    = (rs_reg + (RSW'(1) << (FB - 1))) >> FB;
        rt_fb_next = rt_full[CW-2:0];
    end

    // ---------------- squares
    logic [SQW-1:0] sq_reg [3];
    logic [SQW-1:0] sq_next [3];
    logic           sat_fc_reg;
    logic [CW-2:0]  rt_fc_reg;
    logic           vfc_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = SQW'(qv_reg[i][CW-1:0]) * SQW'(qv_reg[i][CW-1:0]);
        end
    end

    // ---------------- square root, one root bit per stage
    logic [SW-1:0] sr_rem_reg  [CW+1];
    logic [CW-1:0] sr_root_reg [CW+1];
    logic          sr_sat_reg  [CW+1];
    logic [CW-2:0] sr_rt_reg   [CW+1];
    logic [CW:0]   sr_v_reg;

    always_ff @(posedge clk)
    begin
        sr_rem_reg[0]  <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
        sr_root_reg[0] <= '0;
        sr_sat_reg[0]  <= sat_fc_reg;
        sr_rt_reg[0]   <= rt_fc_reg;
    end

    for (genvar k = 1; k <= CW; k++)
    begin : g_sqrt
        localparam int BIT = CW - k;
        logic [SW-1:0] trial;
        logic [SW-1:0] rem_next;
        logic [CW-1:0] root_next;

        assign trial = (SW'(sr_root_reg[k-1]) << (BIT + 1)) + (SW'(1) << (2 * BIT));

        always_comb
        begin
            rem_next  = sr_rem_reg[k-1];
            root_next = sr_root_reg[k-1];
            if (sr_rem_reg[k-1] >= trial)
            begin
                rem_next  = sr_rem_reg[k-1] - trial;
                root_next = sr_root_reg[k-1] | (CW'(1) << BIT);
            end
        end

        always_ff @(posedge clk)
        begin
            sr_rem_reg[k]  <= rem_next;
            sr_root_reg[k] <= root_next;
            sr_sat_reg[k]  <= sr_sat_reg[k-1];
            sr_rt_reg[k]   <= sr_rt_reg[k-1];
        end
    end

    // ---------------- round to nearest, saturate
    logic [CW:0]   rnd_root;
    result_t       result_reg, result_next;
    logic          done_reg;

    always_comb
    begin
        rnd_root = (CW+1)'(sr_root_reg[CW])
                 + (CW+1)'(sr_rem_reg[CW] > SW'(sr_root_reg[CW]));
        result_next.ray_t = sr_rt_reg[CW];
        if (sr_sat_reg[CW] || rnd_root[CW])
        begin
            result_next.closest_distance = MAX_DIST;
        end
        else
        begin
            result_next.closest_distance = rnd_root[CW-1:0];
        end
    end

    // ---------------- payload registers
    always_ff @(posedge clk)
    begin
        ctx1_reg    <= ctx1_next;
        ctx2_reg    <= ctx2_next;
        ctx3_reg    <= ctx2_reg;
        pp3_reg     <= pp3_next;
        neg3_reg    <= neg3_next;
        ctx4_reg    <= ctx3_reg;
        prod4_reg   <= prod4_next;
        ctx5_reg    <= ctx4_reg;
        den5_reg    <= den5_next;
        num5_reg    <= num5_next;
        force5_reg  <= force5_next;
        ctxta_reg   <= ctxta_next;
        bs_reg      <= bs_next;
        ctxtb_reg   <= ctxta_reg;
        numtb_reg   <= numtb_next;
        dentb_reg   <= dentb_next;
        forcetb_reg <= forcetb_next;
        ctxsa_reg   <= ctxsa_next;
        bt_reg      <= bt_next;
        ctxsb_reg   <= ctxsa_reg;
        numsb_reg   <= numsb_next;
        densb_reg   <= densb_next;
        forcesb_reg <= forcesb_next;
        ctxfa_reg   <= ctx_d3;
        us_reg      <= us_next;
        vt_reg      <= vt_next;
        rs_reg      <= rs_next;
        qv_reg      <= qv_next;
        sat_fb_reg  <= sat_fb_next;
        rt_fb_reg   <= rt_fb_next;
        sq_reg      <= sq_next;
        sat_fc_reg  <= sat_fb_reg;
        rt_fc_reg   <= rt_fb_reg;
        result_reg  <= result_next;
    end

    // ---------------- valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            vta_reg  <= 1'b0;
            vtb_reg  <= 1'b0;
            vsa_reg  <= 1'b0;
            vsb_reg  <= 1'b0;
            vfa_reg  <= 1'b0;
            vfb_reg  <= 1'b0;
            vfc_reg  <= 1'b0;
            sr_v_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= start;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            vta_reg  <= d1_valid;
            vtb_reg  <= vta_reg;
            vsa_reg  <= d2_valid;
            vsb_reg  <= vsa_reg;
            vfa_reg  <= d3_valid;
            vfb_reg  <= vfa_reg;
            vfc_reg  <= vfb_reg;
            sr_v_reg <= {sr_v_reg[CW-1:0], vfc_reg};
            done_reg <= sr_v_reg[CW];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/rscd_checker.sv =====
// ----------------------------------------------------------------------------
// rscd_checker
// Port-level checks of the closest distance unit: fixed latency, no stall, ray_t within the ray range.
// ----------------------------------------------------------------------------
module rscd_checker #(
    parameter int LATENCY = 90
) (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input rscd_pkg::query_t  query,
    input logic              done,
    input rscd_pkg::result_t result
);
    import rscd_pkg::*;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("unit raised busy");

    a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("accepted word produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching word");

    a_ray_t_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.ray_t <= $past(query.ray_range, LATENCY))
        else $error("ray_t beyond ray range");

endmodule

bind ray_segment_closest_distance_unit rscd_checker #(
    .LATENCY (LATENCY)
) u_rscd_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .query  (query),
    .done   (done),
    .result (result)
);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ray/segment closest distance unit: a directed
// table, then random queries, each result checked against a predictor or hand value.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rscd_pkg::*;

    typedef logic signed [191:0] acc_t;

    localparam int   FRAC      = 16;
    localparam int   LATENCY   = 3 * FRAC + COORD_WIDTH + 18;
    localparam int   N_RANDOM  = 550;
    localparam acc_t FRAC_ONE  = acc_t'(1) <<< FRAC;
    localparam acc_t DIST_MAX  = (acc_t'(1) <<< COORD_WIDTH) - 1;
    localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    query_t  query;
    logic    done;
    result_t result;

    result_t pending_results[$];
    int      errors;
    int      n_checked;

    ray_segment_closest_distance_unit #(.FRACTION_BITS(FRAC)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .query  (query),
        .done   (done),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        #200000;
        $display("FAIL");
        $finish;
    end

    function automatic void expect_word(result_t r);
        pending_results = {pending_results, r};
    endfunction

    function automatic acc_t dot3(acc_t x[3], acc_t y[3]);
        return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
    endfunction

    // clamp(num/den) to 0..1, truncated, in Q1.FRAC
    function automatic acc_t clamp_frac(acc_t num, acc_t den);
        if (num <= 0)
            return 0;
        if (num >= den)
            return FRAC_ONE;
        return (num <<< FRAC) / den;
    endfunction

    function automatic result_t closest_approach(query_t q);
        acc_t    w[3], v[3], u[3], dv[3];
        acc_t    rng, pm, mag, a, b, c, d, e, den, s, t, sum, root_v, cc, rt;
        logic    sat;
        result_t r;
        w[0]  = acc_t'(q.origin_from_start_x);
        w[1]  = acc_t'(q.origin_from_start_y);
        w[2]  = acc_t'(q.origin_from_start_z);
        v[0]  = acc_t'(q.segment_x);
        v[1]  = acc_t'(q.segment_y);
        v[2]  = acc_t'(q.segment_z);
        dv[0] = acc_t'(q.dir_x);
        dv[1] = acc_t'(q.dir_y);
        dv[2] = acc_t'(q.dir_z);
        rng   = acc_t'({1'b0, q.ray_range});
        for (int i = 0; i < 3; i++)
        begin
            pm   = dv[i] * rng;
            mag  = (pm < 0) ? -pm : pm;
            mag  = (mag + (acc_t'(1) <<< (DIR_FRAC - 1))) >>> DIR_FRAC;
            u[i] = (pm < 0) ? -mag : mag;
        end
        a   = dot3(u, u);
        b   = dot3(u, v);
        c   = dot3(v, v);
        d   = dot3(u, w);
        e   = dot3(v, w);
        den = a * c - b * b;
        s = (den > acc_t'(EPS_DET)) ? clamp_frac(b * e - c * d, den) : 0;
        t = (c > acc_t'(EPS_DOT)) ? clamp_frac(b * s + e * FRAC_ONE, c * FRAC_ONE) : 0;
        s = (a > acc_t'(EPS_DOT)) ? clamp_frac(b * t - d * FRAC_ONE, a * FRAC_ONE) : 0;
        rt = (s * rng + (acc_t'(1) <<< (FRAC - 1))) >>> FRAC;
        r.ray_t = rt[RANGE_WIDTH-1:0];
        sat = 1'b0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            pm  = w[i] * FRAC_ONE + u[i] * s - v[i] * t;
            mag = (pm < 0) ? -pm : pm;
            mag = (mag + (acc_t'(1) <<< (FRAC - 1))) >>> FRAC;
            if (mag > DIST_MAX)
                sat = 1'b1;
            else
                sum = sum + mag * mag;
        end
        if (sat)
            root_v = DIST_MAX;
        else
        begin
            root_v = 0;
            for (int bb = COORD_WIDTH - 1; bb >= 0; bb--)
            begin
                cc = root_v | (acc_t'(1) <<< bb);
                if (cc * cc <= sum)
                    root_v = cc;
            end
            if (sum > root_v * root_v + root_v)
                root_v = root_v + 1;
            if (root_v > DIST_MAX)
                root_v = DIST_MAX;
        end
        r.closest_distance = root_v[COORD_WIDTH-1:0];
        return r;
    endfunction

    // Check each result word against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, result);
                errors++;
            end
            else
            begin
                result_t exp_r;
                exp_r = pending_results.pop_front();
                n_checked++;
                if (result.closest_distance !== exp_r.closest_distance)
                begin
                    $display("%0t: closest_distance expected %0d actual %0d", $time,
                             exp_r.closest_distance, result.closest_distance);
                    errors++;
                end
                if (result.ray_t !== exp_r.ray_t)
                begin
                    $display("%0t: ray_t expected %0d actual %0d", $time,
                             exp_r.ray_t, result.ray_t);
                    errors++;
                end
            end
        end
    end

    // Drive one query word; called just after a falling edge.
    task automatic send_query(query_t q, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        query <= q;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        expect_word(closest_approach(q));
        @(negedge clk);
    endtask

    function automatic logic signed [COORD_WIDTH-1:0] rand_coord(int shape);
        logic signed [COORD_WIDTH-1:0] x;
        x = COORD_WIDTH'($urandom);
        case (shape)
            0:       return x;
            1:       return COORD_WIDTH'($signed($urandom_range(0, 2 * 65536)) - 65536);
            default: return COORD_WIDTH'($signed($urandom_range(0, 2 * 1048576)) - 1048576);
        endcase
    endfunction

    function automatic query_t rand_query();
        query_t q;
        int     shape;
        shape = $urandom_range(0, 9);
        shape = (shape < 2) ? 0 : (shape < 6) ? 1 : 2;
        q.origin_from_start_x = rand_coord(shape);
        q.origin_from_start_y = rand_coord(shape);
        q.origin_from_start_z = rand_coord(shape);
        q.segment_x = rand_coord(shape);
        q.segment_y = rand_coord(shape);
        q.segment_z = rand_coord(shape);
        if (shape == 0)
        begin
            q.dir_x     = DIR_WIDTH'($urandom);
            q.dir_y     = DIR_WIDTH'($urandom);
            q.dir_z     = DIR_WIDTH'($urandom);
            q.ray_range = RANGE_WIDTH'($urandom);
        end
        else
        begin
            q.dir_x     = DIR_WIDTH'($signed($urandom_range(0, 32768)) - 16384);
            q.dir_y     = DIR_WIDTH'($signed($urandom_range(0, 32768)) - 16384);
            q.dir_z     = DIR_WIDTH'($signed($urandom_range(0, 32768)) - 16384);
            q.ray_range = RANGE_WIDTH'($urandom_range(0, 2 * 1048576));
        end
        // sometimes make the segment a zero-length point or the ray empty
        case ($urandom_range(0, 15))
            0:       {q.segment_x, q.segment_y, q.segment_z} = '0;
            1:       q.ray_range = '0;
            2:       {q.dir_x, q.dir_y, q.dir_z} = '0;
            default: ;
        endcase
        return q;
    endfunction

    typedef struct {
        query_t  q;
        logic    typed;
        result_t r;
    } dir_row_t;

    dir_row_t dir_rows[$];

    function automatic void add_row(query_t q, logic typed, result_t r);
        dir_row_t row_v;
        row_v.q     = q;
        row_v.typed = typed;
        row_v.r     = r;
        dir_rows    = {dir_rows, row_v};
    endfunction

    function automatic query_t mk(logic signed [COORD_WIDTH-1:0] wx, wy, wz, vx, vy, vz,
                                  logic signed [DIR_WIDTH-1:0] dx, dy, dz,
                                  logic [RANGE_WIDTH-1:0] rr);
        query_t q;
        q = '{wx, wy, wz, vx, vy, vz, dx, dy, dz, rr};
        return q;
    endfunction

    initial
    begin
        query_t   q;
        dir_row_t row;
        int       gap;
        errors    = 0;
        n_checked = 0;
        rst_n     = 1'b0;
        start     = 1'b0;
        query     = '0;

        // zero query, a point-to-point distance of 4096 and an empty ray, results known by hand
        add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '{0, 0});
        add_row(mk(4096, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '{4096, 0});
        add_row(mk(0, 0, 0, 0, 0, 0, 16384, 0, 0, 0), 1'b1, '{0, 0});
        // extremes of the coordinates
        add_row(mk(C_MIN, C_MIN, C_MIN, 0, 0, 0, 0, 0, 0, 0), 1'b0, '{0, 0});
        add_row(mk(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN,
                   0, 0, 0, 0), 1'b0, '{0, 0});
        add_row(mk(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX,
                   -16384, -16384, -16384, '1), 1'b0, '{0, 0});
        add_row(mk(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX,
                   -32768, 32767, -32768, '1), 1'b0, '{0, 0});
        // parallel ray and segment
        add_row(mk(0, 4096, 0, 40960, 0, 0, 16384, 0, 0, 20480), 1'b0, '{0, 0});
        // crossing lines
        add_row(mk(-8192, 4096, 0, 0, 16384, 0, 16384, 0, 0, 16384), 1'b0, '{0, 0});
        // zero-length segment, zero-length ray, zero direction
        add_row(mk(4096, 4096, 4096, 0, 0, 0, 0, 16384, 0, 32768), 1'b0, '{0, 0});
        add_row(mk(4096, -4096, 0, 8192, 0, 0, 0, 0, 16384, 0), 1'b0, '{0, 0});
        add_row(mk(100, 200, 300, 8192, 0, 0, 0, 0, 0, '1), 1'b0, '{0, 0});
        // direction not unit length at full range, then a near-unit diagonal one
        add_row(mk(-4096, 0, 0, 0, 8192, 8192, 32767, 32767, 32767, '1), 1'b0, '{0, 0});
        add_row(mk(12345, -6789, 4242, -99999, 55555, 1, 9459, 9459, 9459, 65536),
                1'b0, '{0, 0});
        // ray pointing away from the segment
        add_row(mk(4096, 0, 0, 0, 4096, 0, 16384, 0, 0, 40960), 1'b0, '{0, 0});

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            send_query(row.q, 0);
            if (row.typed)
            begin
                void'(pending_results.pop_back());
                expect_word(row.r);
            end
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            q   = rand_query();
            gap = 0;
            if ((n < 200 || n >= 320) && $urandom_range(0, 99) < 13)
                gap = $urandom_range(1, 4);
            // hold off until the pipe has drained once
            if (n == 400)
            begin
                start <= 1'b0;
                while (pending_results.size() != 0)
                    @(negedge clk);
                gap = 0;
            end
            send_query(q, gap);
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        $display("Checked %0d result words: %0d directed queries, %0d random ones.",
                 n_checked, dir_rows.size(), N_RANDOM);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rscd_pkg.sv
rtl/rscd_frac_div.sv
rtl/ray_segment_closest_distance_unit.sv
rtl/rscd_checker.sv
test/tb.sv
